/* hw/rtl/line_follow_steering_fsm_core_assert.svh */
// Assertion macros for the line-follow steering core, clocked on clk_i, disabled in reset.
`ifndef LINE_FOLLOW_STEERING_FSM_CORE_ASSERT_SVH
`define LINE_FOLLOW_STEERING_FSM_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lfs_pkg.sv */
// Types and constants for the line-follow steering core.
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int unsigned PULSE_W = 11;
  localparam int unsigned CNT_W   = 8;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Servo pulse widths in microseconds.
  localparam pulse_t PULSE_MIN     = 11'd1000;
  localparam pulse_t PULSE_MAX     = 11'd2000;
  localparam pulse_t PULSE_NEUTRAL = 11'd1500;
  localparam pulse_t FWD_L         = 11'd1553;
  localparam pulse_t FWD_R         = 11'd1445;
  localparam pulse_t SLIGHT_L_L    = 11'd1530;
  localparam pulse_t SLIGHT_L_R    = 11'd1410;
  localparam pulse_t SLIGHT_R_L    = 11'd1590;
  localparam pulse_t SLIGHT_R_R    = 11'd1470;
  localparam pulse_t PIVOT_R_L     = 11'd1575;
  localparam pulse_t PIVOT_R_R     = 11'd1500;
  localparam pulse_t PIVOT_L_L     = 11'd1500;
  localparam pulse_t PIVOT_L_R     = 11'd1420;

  // Sensor patterns, bits 3..0.
  localparam logic [3:0] PAT_CENTER   = 4'b0110;
  localparam logic [3:0] PAT_NEAR_L   = 4'b0100;
  localparam logic [3:0] PAT_NEAR_R   = 4'b0010;
  localparam logic [3:0] PAT_SR_A     = 4'b1100;
  localparam logic [3:0] PAT_SR_B     = 4'b0001;
  localparam logic [3:0] PAT_SL_A     = 4'b0011;
  localparam logic [3:0] PAT_SL_B     = 4'b1000;
  localparam logic [3:0] PAT_HARD_R   = 4'b1110;
  localparam logic [3:0] PAT_HARD_L   = 4'b0111;

  localparam cnt_t RST_LOST_TIMEOUT  = 8'd40;
  localparam cnt_t RST_SNAP_DURATION = 8'd40;
  localparam cnt_t RST_EDGE_PERSIST  = 8'd6;

  typedef enum logic [1:0] {
    CFG_LOST_TIMEOUT  = 2'd0,
    CFG_SNAP_DURATION = 2'd1,
    CFG_EDGE_PERSIST  = 2'd2
  } cfg_idx_e;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PRESS = 1'b1;

  // Reported mode codes.
  localparam logic [2:0] MODE_CODE_FOLLOW = 3'd0;
  localparam logic [2:0] MODE_CODE_SPIN_R = 3'd1;
  localparam logic [2:0] MODE_CODE_SPIN_L = 3'd2;
  localparam logic [2:0] MODE_CODE_SNAP_L = 3'd3;
  localparam logic [2:0] MODE_CODE_SNAP_R = 3'd4;

  typedef enum logic [4:0] {
    MODE_FOLLOW = 5'b00001,
    MODE_SPIN_R = 5'b00010,
    MODE_SPIN_L = 5'b00100,
    MODE_SNAP_L = 5'b01000,
    MODE_SNAP_R = 5'b10000
  } mode_e;

  typedef struct packed {
    logic       func;
    logic [3:0] line_bits;
  } in_t;

  typedef struct packed {
    pulse_t     left_pulse_us;
    pulse_t     right_pulse_us;
    logic       running;
    logic [2:0] mode;
  } out_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    unique case (m)
      MODE_FOLLOW: c = MODE_CODE_FOLLOW;
      MODE_SPIN_R: c = MODE_CODE_SPIN_R;
      MODE_SPIN_L: c = MODE_CODE_SPIN_L;
      MODE_SNAP_L: c = MODE_CODE_SNAP_L;
      MODE_SNAP_R: c = MODE_CODE_SNAP_R;
      default:     c = MODE_CODE_FOLLOW;
    endcase
    return c;
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

endpackage

/* hw/rtl/line_follow_steering_fsm_core.sv */
// Line-follow steering controller: run/stop toggle, pattern classifier and spin/snap FSM.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one transaction per
//   0.5 ms tick (func = tick, line_bits = sensors) or per button press (func = press).
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   transaction per input: held left/right servo pulses, run flag and mode code.
//   Config channel (cfg_valid_i / cfg_ready_o) writes lost_timeout (0),
//   snap_duration (1) and edge_persist (2); other indexes are dropped. Write only
//   while no transaction is in flight.
// Flow: an accepted transaction waits in the input register; the state update is
//   combinational logic from there into the state/result registers, and the core takes
//   one transaction per cycle while the output is not stalled.
// Reset: stopped, follow mode, counters zero, both pulses neutral (1500 us),
//   registers at 40 / 40 / 6.
// Stall: a stalled result holds; the input register then fills and in_stall_o
//   rises while it is occupied and the result is still waiting.
module line_follow_steering_fsm_core
  import lfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  cnt_t       cfg_data_i
);

  logic   in_vld_q, in_vld_d;
  in_t    in_q;
  logic   out_vld_q, out_vld_d;
  logic   out_free, in_acc, adv;

  cnt_t   lost_timeout_q, snap_duration_q, edge_persist_q;

  logic   run_q, run_d;
  mode_e  mode_q, mode_d;
  cnt_t   rer_q, rer_d;
  cnt_t   ler_q, ler_d;
  cnt_t   snap_q, snap_d;
  cnt_t   lost_q, lost_d;
  pulse_t left_q, left_d;
  pulse_t right_q, right_d;

  logic   centered, pat_near, pat_veer_r, pat_veer_l;
  cnt_t   rer_tick, ler_tick, lost_inc;
  logic   [3:0] p;

  // Handshake
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d  = adv ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_timeout_q  <= RST_LOST_TIMEOUT;
      snap_duration_q <= RST_SNAP_DURATION;
      edge_persist_q  <= RST_EDGE_PERSIST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOST_TIMEOUT:  lost_timeout_q  <= cfg_data_i;
        CFG_SNAP_DURATION: snap_duration_q <= cfg_data_i;
        CFG_EDGE_PERSIST:  edge_persist_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pattern classification
  assign p          = in_q.line_bits;
  assign centered   = (p == PAT_CENTER);
  assign pat_near   = (p == PAT_CENTER) || (p == PAT_NEAR_L) || (p == PAT_NEAR_R);
  assign pat_veer_r = (p == PAT_SR_A) || (p == PAT_SR_B);
  assign pat_veer_l = (p == PAT_SL_A) || (p == PAT_SL_B);
  assign rer_tick   = (p == PAT_HARD_R) ? sat_inc(rer_q) : '0;
  assign ler_tick   = (p == PAT_HARD_L) ? sat_inc(ler_q) : '0;
  assign lost_inc   = sat_inc(lost_q);

  always_comb begin
    run_d   = run_q;
    mode_d  = mode_q;
    rer_d   = rer_q;
    ler_d   = ler_q;
    snap_d  = snap_q;
    lost_d  = lost_q;
    left_d  = left_q;
    right_d = right_q;
    if (in_q.func == FUNC_PRESS) begin
      if (run_q) begin
        run_d   = 1'b0;
        left_d  = PULSE_NEUTRAL;
        right_d = PULSE_NEUTRAL;
      end else begin
        run_d   = 1'b1;
        mode_d  = MODE_FOLLOW;
        rer_d   = '0;
        ler_d   = '0;
        snap_d  = '0;
        lost_d  = '0;
        left_d  = FWD_L;
        right_d = FWD_R;
      end
    end else if (run_q) begin
      rer_d = rer_tick;
      ler_d = ler_tick;
      unique case (mode_q)
        MODE_SPIN_R, MODE_SPIN_L: begin
          lost_d = '0;
          // Centering out of a spin starts the counter-pivot.
          if (centered) begin
            mode_d  = (mode_q == MODE_SPIN_R) ? MODE_SNAP_L : MODE_SNAP_R;
            snap_d  = snap_duration_q;
            left_d  = (mode_q == MODE_SPIN_R) ? PIVOT_L_L : PIVOT_R_L;
            right_d = (mode_q == MODE_SPIN_R) ? PIVOT_L_R : PIVOT_R_R;
          end else begin
            left_d  = (mode_q == MODE_SPIN_R) ? PIVOT_R_L : PIVOT_L_L;
            right_d = (mode_q == MODE_SPIN_R) ? PIVOT_R_R : PIVOT_L_R;
          end
        end
        MODE_SNAP_L, MODE_SNAP_R: begin
          lost_d = '0;
          if (snap_q != '0) begin
            snap_d  = snap_q - cnt_t'(1);
            left_d  = (mode_q == MODE_SNAP_L) ? PIVOT_L_L : PIVOT_R_L;
            right_d = (mode_q == MODE_SNAP_L) ? PIVOT_L_R : PIVOT_R_R;
          end else begin
            mode_d  = MODE_FOLLOW;
            left_d  = FWD_L;
            right_d = FWD_R;
          end
        end
        default: begin
          priority if (rer_tick >= edge_persist_q) begin
            mode_d  = MODE_SPIN_R;
            rer_d   = '0;
            lost_d  = '0;
            left_d  = PIVOT_R_L;
            right_d = PIVOT_R_R;
          end else if (ler_tick >= edge_persist_q) begin
            mode_d  = MODE_SPIN_L;
            ler_d   = '0;
            lost_d  = '0;
            left_d  = PIVOT_L_L;
            right_d = PIVOT_L_R;
          end else if (pat_near) begin
            lost_d  = '0;
            left_d  = FWD_L;
            right_d = FWD_R;
          end else if (pat_veer_r) begin
            lost_d  = '0;
            left_d  = SLIGHT_R_L;
            right_d = SLIGHT_R_R;
          end else if (pat_veer_l) begin
            lost_d  = '0;
            left_d  = SLIGHT_L_L;
            right_d = SLIGHT_L_R;
          end else begin
            // Line lost: hold last command until the timeout, then drive both pulses neutral (run flag stays set).
            if (lost_inc >= lost_timeout_q) begin
              lost_d  = lost_timeout_q;
              left_d  = PULSE_NEUTRAL;
              right_d = PULSE_NEUTRAL;
            end else begin
              lost_d  = lost_inc;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      mode_q  <= MODE_FOLLOW;
      rer_q   <= '0;
      ler_q   <= '0;
      snap_q  <= '0;
      lost_q  <= '0;
      left_q  <= PULSE_NEUTRAL;
      right_q <= PULSE_NEUTRAL;
    end else if (adv) begin
      run_q   <= run_d;
      mode_q  <= mode_d;
      rer_q   <= rer_d;
      ler_q   <= ler_d;
      snap_q  <= snap_d;
      lost_q  <= lost_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // State only moves when a result is loaded, so it doubles as the result register.
  assign out_valid_o               = out_vld_q;
  assign out_data_o.left_pulse_us  = left_q;
  assign out_data_o.right_pulse_us = right_q;
  assign out_data_o.running        = run_q;
  assign out_data_o.mode           = mode_code(mode_q);

endmodule

/* hw/rtl/lfs_checker.sv */
// Port-level assertion checker for the line-follow steering core, with its bind.
`timescale 1ns / 1ps

`include "line_follow_steering_fsm_core_assert.svh"

module lfs_checker
  import lfs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_t       out_data_o
);

  `LFS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `LFS_ASSERT_IMP(a_no_stall_when_empty, !out_valid_o, !in_stall_o, "input stalled with no pending result")
  `LFS_ASSERT_IMP(a_pulse_range, out_valid_o, (out_data_o.left_pulse_us >= PULSE_MIN) && (out_data_o.left_pulse_us <= PULSE_MAX) && (out_data_o.right_pulse_us >= PULSE_MIN) && (out_data_o.right_pulse_us <= PULSE_MAX), "pulse out of range")
  `LFS_ASSERT_IMP(a_stopped_neutral, out_valid_o && !out_data_o.running, (out_data_o.left_pulse_us == PULSE_NEUTRAL) && (out_data_o.right_pulse_us == PULSE_NEUTRAL), "stopped but servos not neutral")
  // A transaction accepted while no stalled result is waiting must show up as a valid result.
  `LFS_ASSERT_NXT(a_accept_result, in_valid_i && !in_stall_o && !(out_valid_o && out_stall_i), ##1 out_valid_o, "accepted transaction lost")

endmodule

bind line_follow_steering_fsm_core lfs_checker u_lfs_checker (.*);
